// ===== rtl/ese_pkg.sv =====
// Shared constants and types for the encoder BCD setpoint editor.
package ese_pkg;

	localparam int LOW_RUN_LEN_DEF = 12;

	localparam int VOLT_TOP   = 2;
	localparam int VOLT_LIMIT = 200;
	localparam int AMP_TOP    = 5;
	localparam int AMP_LIMIT  = 500;

	localparam logic [3:0] DIGIT_MAX = 4'd9;

	// Cursor column codes
	localparam logic [1:0] COL_HI      = 2'd0;
	localparam logic [1:0] COL_MID     = 2'd1;
	localparam logic [1:0] COL_AMP_LO  = 2'd2;
	localparam logic [1:0] COL_VOLT_LO = 2'd3;

	typedef struct packed {
		logic [1:0] col;
		logic       on_current;
	} cursor_t;

	localparam cursor_t CURSOR_RESET = '{col: COL_VOLT_LO, on_current: 1'b0};

endpackage

// ===== rtl/ese_sample_if.sv =====
// Input channel: one encoder pin sample and button events per beat.
interface ese_sample_if;
	logic valid;
	logic ready;
	logic clk_level;
	logic dt_level;
	logic select_pressed;
	logic right_pressed;
	logic left_pressed;
	logic output_pressed;

	modport source (output valid, output clk_level, output dt_level, output select_pressed,
		output right_pressed, output left_pressed, output output_pressed, input ready);
	modport sink (input valid, input clk_level, input dt_level, input select_pressed,
		input right_pressed, input left_pressed, input output_pressed, output ready);
endinterface

// ===== rtl/ese_result_if.sv =====
// Result channel: setpoint digits, totals, cursor and output state per beat.
interface ese_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] volt_tens_digit;
	logic [3:0] volt_units_digit;
	logic [3:0] volt_tenths_digit;
	logic [2:0] amp_hundreds_digit;
	logic [3:0] amp_tens_digit;
	logic [3:0] amp_units_digit;
	logic [7:0] voltage_tenths_total;
	logic [8:0] current_ma_total;
	logic [1:0] cursor_col;
	logic       cursor_on_current;
	logic       output_on;
	logic       knob_step;

	modport source (output valid, output volt_tens_digit, output volt_units_digit,
		output volt_tenths_digit, output amp_hundreds_digit, output amp_tens_digit,
		output amp_units_digit, output voltage_tenths_total, output current_ma_total,
		output cursor_col, output cursor_on_current, output output_on, output knob_step,
		input ready);
	modport sink (input valid, input volt_tens_digit, input volt_units_digit,
		input volt_tenths_digit, input amp_hundreds_digit, input amp_tens_digit,
		input amp_units_digit, input voltage_tenths_total, input current_ma_total,
		input cursor_col, input cursor_on_current, input output_on, input knob_step,
		output ready);
endinterface

// ===== rtl/encoder_bcd_setpoint_editor.sv =====
// Encoder-driven BCD setpoint editor for a bench supply.
// Takes one beat per clock and returns one result beat per input beat. A beat is
// registered at the input, then the step detector, both setpoint editors and the
// cursor logic update the state in one pass, and the state registers drive the
// result port; result valid is registered behind the input stage, and
// throughput is one beat per cycle as long as the result side takes its beats.
// An encoder step fires when the clock level history reads one high sample followed
// by LOW_RUN_LEN low samples. Setpoints clamp to 00.0..20.0 V and 000..500 mA.
module encoder_bcd_setpoint_editor import ese_pkg::*; #(
	parameter int LOW_RUN_LEN = LOW_RUN_LEN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ese_sample_if.sink   sample,
	ese_result_if.source result
);
	// input stage
	logic valid_s1;
	logic clk_level_s1, dt_level_s1;
	logic select_s1, right_s1, left_s1, output_s1;

	// state, which also forms the result beat
	logic       out_valid_q;
	logic [1:0] volt_tens_q;
	logic [3:0] volt_units_q, volt_tenths_q;
	logic [2:0] amp_hundreds_q;
	logic [3:0] amp_tens_q, amp_units_q;
	logic [7:0] volt_total_q;
	logic [8:0] amp_total_q;
	cursor_t    cur_q;
	logic       output_on_q;
	logic       step_q;

	logic       advance;
	logic       fire;
	logic [1:0] volt_tens_nx;
	logic [3:0] volt_units_nx, volt_tenths_nx;
	logic [2:0] amp_hundreds_nx;
	logic [3:0] amp_tens_nx, amp_units_nx;
	logic [7:0] volt_total_nx;
	logic [8:0] amp_total_nx;
	cursor_t    cur_nx;

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			clk_level_s1 <= sample.clk_level;
			dt_level_s1  <= sample.dt_level;
			select_s1    <= sample.select_pressed;
			right_s1     <= sample.right_pressed;
			left_s1      <= sample.left_pressed;
			output_s1    <= sample.output_pressed;
		end
	end

	ese_step_det #(
		.LOW_RUN_LEN (LOW_RUN_LEN)
	) u_step_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.clk_level (clk_level_s1),
		.fire      (fire)
	);

	ese_bcd_edit #(
		.HI_W    (2),
		.TOP     (VOLT_TOP),
		.LIMIT   (VOLT_LIMIT),
		.LO_COL  (int'(COL_VOLT_LO)),
		.TOTAL_W (8)
	) u_volt_edit (
		.en       (fire && !cur_q.on_current),
		.up       (dt_level_s1),
		.col      (cur_q.col),
		.hi       (volt_tens_q),
		.mid      (volt_units_q),
		.lo       (volt_tenths_q),
		.hi_nx    (volt_tens_nx),
		.mid_nx   (volt_units_nx),
		.lo_nx    (volt_tenths_nx),
		.total_nx (volt_total_nx)
	);

	ese_bcd_edit #(
		.HI_W    (3),
		.TOP     (AMP_TOP),
		.LIMIT   (AMP_LIMIT),
		.LO_COL  (int'(COL_AMP_LO)),
		.TOTAL_W (9)
	) u_amp_edit (
		.en       (fire && cur_q.on_current),
		.up       (dt_level_s1),
		.col      (cur_q.col),
		.hi       (amp_hundreds_q),
		.mid      (amp_tens_q),
		.lo       (amp_units_q),
		.hi_nx    (amp_hundreds_nx),
		.mid_nx   (amp_tens_nx),
		.lo_nx    (amp_units_nx),
		.total_nx (amp_total_nx)
	);

	ese_cursor u_cursor (
		.cur            (cur_q),
		.select_pressed (select_s1),
		.right_pressed  (right_s1),
		.left_pressed   (left_s1),
		.cur_nx         (cur_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			volt_tens_q    <= '0;
			volt_units_q   <= '0;
			volt_tenths_q  <= '0;
			amp_hundreds_q <= '0;
			amp_tens_q     <= '0;
			amp_units_q    <= '0;
			volt_total_q   <= '0;
			amp_total_q    <= '0;
			cur_q          <= CURSOR_RESET;
			output_on_q    <= 1'b0;
			step_q         <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				volt_tens_q    <= volt_tens_nx;
				volt_units_q   <= volt_units_nx;
				volt_tenths_q  <= volt_tenths_nx;
				amp_hundreds_q <= amp_hundreds_nx;
				amp_tens_q     <= amp_tens_nx;
				amp_units_q    <= amp_units_nx;
				volt_total_q   <= volt_total_nx;
				amp_total_q    <= amp_total_nx;
				cur_q          <= cur_nx;
				output_on_q    <= output_on_q ^ output_s1;
				step_q         <= fire;
			end
		end
	end

	assign result.valid                = out_valid_q;
	assign result.volt_tens_digit      = volt_tens_q;
	assign result.volt_units_digit     = volt_units_q;
	assign result.volt_tenths_digit    = volt_tenths_q;
	assign result.amp_hundreds_digit   = amp_hundreds_q;
	assign result.amp_tens_digit       = amp_tens_q;
	assign result.amp_units_digit      = amp_units_q;
	assign result.voltage_tenths_total = volt_total_q;
	assign result.current_ma_total     = amp_total_q;
	assign result.cursor_col           = cur_q.col;
	assign result.cursor_on_current    = cur_q.on_current;
	assign result.output_on            = output_on_q;
	assign result.knob_step            = step_q;

	a_volt_limit : assert property (@(posedge clk) disable iff (!arst_n)
		volt_total_q <= 8'(VOLT_LIMIT))
		else $error("voltage setpoint above limit");

	a_amp_limit : assert property (@(posedge clk) disable iff (!arst_n)
		amp_total_q <= 9'(AMP_LIMIT))
		else $error("current setpoint above limit");

	a_cursor_col : assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q.on_current && cur_q.col != COL_VOLT_LO) ||
		(!cur_q.on_current && cur_q.col != COL_AMP_LO))
		else $error("cursor on a column its row does not have");

	a_stall_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> $stable(cur_q) && $stable(volt_total_q)
		&& $stable(amp_total_q))
		else $error("state changed while result beat stalled");
endmodule

// ===== rtl/ese_step_det.sv =====
// Encoder clock history register and step detector.
module ese_step_det #(
	parameter int LOW_RUN_LEN = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic clk_level,
	output logic fire
);
	localparam int HIST_W = LOW_RUN_LEN + 1;
	localparam logic [HIST_W-1:0] HIST_FIRE = {1'b1, {LOW_RUN_LEN{1'b0}}};

	logic [HIST_W-1:0] hist_q;
	logic [HIST_W-1:0] hist_next;

	assign hist_next = {hist_q[HIST_W-2:0], clk_level};
	assign fire      = (hist_next == HIST_FIRE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (advance) begin
			// clear the history once a step fires
			hist_q <= fire ? '0 : hist_next;
		end
	end
endmodule

// ===== rtl/ese_bcd_edit.sv =====
// One three-digit BCD setpoint: increment with carry and clamp, decrement with borrow.
module ese_bcd_edit import ese_pkg::*; #(
	parameter int HI_W    = 2,
	parameter int TOP     = 2,
	parameter int LIMIT   = 200,
	parameter int LO_COL  = 3,
	parameter int TOTAL_W = 8
) (
	input  logic               en,
	input  logic               up,
	input  logic [1:0]         col,
	input  logic [HI_W-1:0]    hi,
	input  logic [3:0]         mid,
	input  logic [3:0]         lo,
	output logic [HI_W-1:0]    hi_nx,
	output logic [3:0]         mid_nx,
	output logic [3:0]         lo_nx,
	output logic [TOTAL_W-1:0] total_nx
);
	localparam int SUM_W = 10;
	localparam logic [HI_W-1:0]  TOP_V  = HI_W'(TOP);
	localparam logic [1:0]       LO_V   = 2'(LO_COL);
	localparam logic [SUM_W-1:0] LIMIT_V = SUM_W'(LIMIT);

	logic [HI_W-1:0]  hi_inc;
	logic [HI_W-1:0]  up_h, dn_h;
	logic [3:0]       up_m, up_l, dn_m, dn_l;
	logic [SUM_W-1:0] up_sum, nx_sum;
	logic             all_zero;

	assign hi_inc   = (hi >= TOP_V) ? TOP_V : hi + HI_W'(1);
	assign all_zero = (hi == '0) && (mid == 4'd0) && (lo == 4'd0);

	always_comb begin
		up_h = hi;
		up_m = mid;
		up_l = lo;
		if (col == COL_HI) begin
			up_h = hi_inc;
		end else if (col == COL_MID) begin
			if (mid >= DIGIT_MAX) begin
				up_m = 4'd0;
				up_h = hi_inc;
			end else begin
				up_m = mid + 4'd1;
			end
		end else if (col == LO_V) begin
			if (lo >= DIGIT_MAX) begin
				up_l = 4'd0;
				if (mid >= DIGIT_MAX) begin
					up_m = 4'd0;
					up_h = hi_inc;
				end else begin
					up_m = mid + 4'd1;
				end
			end else begin
				up_l = lo + 4'd1;
			end
		end
		up_sum = SUM_W'(up_h) * SUM_W'(100) + SUM_W'(up_m) * SUM_W'(10) + SUM_W'(up_l);
		// clamp the whole setpoint at its limit
		if (up_sum > LIMIT_V) begin
			up_h = TOP_V;
			up_m = 4'd0;
			up_l = 4'd0;
		end
	end

	always_comb begin
		dn_h = hi;
		dn_m = mid;
		dn_l = lo;
		if (!all_zero) begin
			if (col == COL_HI) begin
				if (hi != '0) dn_h = hi - HI_W'(1);
			end else if (col == COL_MID) begin
				if (mid != 4'd0) begin
					dn_m = mid - 4'd1;
				end else if (hi != '0) begin
					dn_m = DIGIT_MAX;
					dn_h = hi - HI_W'(1);
				end
			end else if (col == LO_V) begin
				if (lo != 4'd0) begin
					dn_l = lo - 4'd1;
				end else begin
					// borrow through the higher digits, at least one of which is known nonzero here
					dn_l = DIGIT_MAX;
					if (mid != 4'd0) begin
						dn_m = mid - 4'd1;
					end else begin
						dn_m = DIGIT_MAX;
						dn_h = hi - HI_W'(1);
					end
				end
			end
		end
	end

	always_comb begin
		if (!en) begin
			hi_nx  = hi;
			mid_nx = mid;
			lo_nx  = lo;
		end else if (up) begin
			hi_nx  = up_h;
			mid_nx = up_m;
			lo_nx  = up_l;
		end else begin
			hi_nx  = dn_h;
			mid_nx = dn_m;
			lo_nx  = dn_l;
		end
		nx_sum   = SUM_W'(hi_nx) * SUM_W'(100) + SUM_W'(mid_nx) * SUM_W'(10) + SUM_W'(lo_nx);
		total_nx = nx_sum[TOTAL_W-1:0];
	end
endmodule

// ===== rtl/ese_cursor.sv =====
// Cursor and row selection: row switch, then right, then left.
module ese_cursor import ese_pkg::*; (
	input  cursor_t cur,
	input  logic    select_pressed,
	input  logic    right_pressed,
	input  logic    left_pressed,
	output cursor_t cur_nx
);
	cursor_t c0, c1, c2;

	always_comb begin
		c0 = cur;
		if (select_pressed) begin
			c0.on_current = !cur.on_current;
			if (!cur.on_current && cur.col == COL_VOLT_LO) c0.col = COL_AMP_LO;
			if (cur.on_current && cur.col == COL_AMP_LO) c0.col = COL_VOLT_LO;
		end

		c1 = c0;
		if (right_pressed) begin
			if (!c0.on_current) begin
				if (c0.col == COL_HI) c1.col = COL_MID;
				else if (c0.col == COL_MID) c1.col = COL_VOLT_LO;
			end else begin
				c1.col = (c0.col < COL_AMP_LO) ? c0.col + 2'd1 : COL_AMP_LO;
			end
		end

		c2 = c1;
		if (left_pressed) begin
			if (!c1.on_current) begin
				if (c1.col == COL_MID) c2.col = COL_HI;
				else if (c1.col == COL_VOLT_LO) c2.col = COL_MID;
			end else begin
				// stray column three on the current row lands on column two
				if (c1.col == COL_HI) c2.col = COL_HI;
				else if (c1.col == COL_VOLT_LO) c2.col = COL_AMP_LO;
				else c2.col = c1.col - 2'd1;
			end
		end

		cur_nx = c2;
	end
endmodule
